// ----- src/vm_resource_wait_table_assert.svh -----
// Assertion macros shared by the checker of the requester wait table.
// Standalone header; nothing else is needed to use it.
`ifndef VM_RESOURCE_WAIT_TABLE_ASSERT_SVH
`define VM_RESOURCE_WAIT_TABLE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define VMRWT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define VMRWT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- src/vmrwt_pkg.sv -----
// Types, constants and helpers for the requester wait table.
// Used by the table, its evaluation unit and its checker.
package vmrwt_pkg;

   localparam int TABLE_DEPTH  = 32;
   localparam int AMOUNT_WIDTH = 16;
   localparam int FIELD_W      = 16;
   localparam int ID_W         = 16;
   localparam int NUM_KINDS    = 3;
   localparam int ADDR_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
   localparam int REM_W        = AMOUNT_WIDTH + 2;

   typedef logic [AMOUNT_WIDTH-1:0] amt_type;
   typedef logic [FIELD_W-1:0]      field_type;
   typedef logic [ID_W-1:0]         id_type;
   typedef logic [ADDR_W-1:0]       addr_type;
   typedef logic [CNT_W-1:0]        cnt_type;
   typedef logic signed [REM_W-1:0] rem_type;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CYCLE  = 2'd2,
      CMD_SAFETY = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type   cmd;
      id_type    requester_id;
      field_type cpu_first;
      field_type mem_first;
      field_type sto_first;
      field_type cpu_second;
      field_type mem_second;
      field_type sto_second;
   } req_type;

   typedef struct packed {
      logic       verdict;
      status_type status;
      cnt_type    entry_count;
   } rsp_type;

   typedef struct packed {
      id_type  id;
      amt_type held_cpu;
      amt_type held_mem;
      amt_type held_sto;
      amt_type wait_cpu;
      amt_type wait_mem;
      amt_type wait_sto;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   // Per-entry findings of the shared evaluation unit.
   typedef struct packed {
      logic                 id_match;
      logic                 fits;
      logic [NUM_KINDS-1:0] held_nz;
      logic [NUM_KINDS-1:0] wait_nz;
   } eval_type;

   function automatic rec_type make_rec(req_type r);
      rec_type rec;
      rec.id       = r.requester_id;
      rec.held_cpu = amt_type'(r.cpu_first);
      rec.held_mem = amt_type'(r.mem_first);
      rec.held_sto = amt_type'(r.sto_first);
      rec.wait_cpu = amt_type'(r.cpu_second);
      rec.wait_mem = amt_type'(r.mem_second);
      rec.wait_sto = amt_type'(r.sto_second);
      return rec;
   endfunction

endpackage

// ----- src/vmrwt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module vmrwt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/vmrwt_entry_eval.sv -----
// Shared evaluation unit: compares one stored record against the current item.
// Depends on vmrwt_pkg.
module vmrwt_entry_eval (
   input  vmrwt_pkg::req_type  req,
   input  vmrwt_pkg::rec_type  rec,
   output vmrwt_pkg::eval_type ev
);

   vmrwt_pkg::rec_type rq;
   vmrwt_pkg::rem_type rem_cpu;
   vmrwt_pkg::rem_type rem_mem;
   vmrwt_pkg::rem_type rem_sto;

   assign rq = vmrwt_pkg::make_rec(req);

   // For a safety check the first amounts are available and the second required.
   assign rem_cpu = vmrwt_pkg::rem_type'({2'b00, rq.held_cpu})
                  - vmrwt_pkg::rem_type'({2'b00, rq.wait_cpu});
   assign rem_mem = vmrwt_pkg::rem_type'({2'b00, rq.held_mem})
                  - vmrwt_pkg::rem_type'({2'b00, rq.wait_mem});
   assign rem_sto = vmrwt_pkg::rem_type'({2'b00, rq.held_sto})
                  - vmrwt_pkg::rem_type'({2'b00, rq.wait_sto});

   always_comb begin
      ev.id_match = (rec.id == req.requester_id);
      ev.fits     = (rem_cpu >= vmrwt_pkg::rem_type'({2'b00, rec.wait_cpu}))
                 && (rem_mem >= vmrwt_pkg::rem_type'({2'b00, rec.wait_mem}))
                 && (rem_sto >= vmrwt_pkg::rem_type'({2'b00, rec.wait_sto}));
      ev.held_nz  = {rec.held_sto != '0, rec.held_mem != '0, rec.held_cpu != '0};
      ev.wait_nz  = {rec.wait_sto != '0, rec.wait_mem != '0, rec.wait_cpu != '0};
   end

endmodule

// ----- src/vm_resource_wait_table.sv -----
// Requester wait table. Every command walks the stored records one per cycle
// through a single evaluation unit fed from a registered-read RAM. A full scan
// ends once the last stored record has been evaluated, and an update ends at
// its matching record. A remove ends its scan at the match and then moves each
// record above it down one place, one per cycle. busy is high from the
// accepting edge until the edge that raises rsp_valid; rsp_valid marks the
// result for exactly one cycle, and the receiver cannot hold it off.
// Depends on vmrwt_pkg, vmrwt_ram and vmrwt_entry_eval.
module vm_resource_wait_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  vmrwt_pkg::req_type req_data,
   output logic               rsp_valid,
   output vmrwt_pkg::rsp_type rsp_data
);

   localparam int NK = vmrwt_pkg::NUM_KINDS;
   localparam logic [1:0] HOLD_SAT = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   state_type           state_ff, state_in;
   vmrwt_pkg::req_type  req_ff, req_in;
   vmrwt_pkg::cnt_type  cnt_ff, cnt_in;
   vmrwt_pkg::cnt_type  iss_ff, iss_in;
   logic                pend_ff, pend_in;
   vmrwt_pkg::addr_type pidx_ff, pidx_in;
   logic [1:0]          hold_cnt_ff [NK];
   logic [1:0]          hold_cnt_in [NK];
   logic [NK-1:0]       wfree_ff, wfree_in;
   logic [NK-1:0]       whold_ff, whold_in;
   logic                fit_ff, fit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   vmrwt_pkg::rsp_type  rsp_ff, rsp_in;

   logic                      wr_en;
   vmrwt_pkg::addr_type       wr_addr;
   logic [vmrwt_pkg::REC_W-1:0] wr_data;
   logic                      rd_en;
   logic [vmrwt_pkg::REC_W-1:0] rd_data;
   vmrwt_pkg::rec_type        rd_rec;
   vmrwt_pkg::eval_type       ev;

   assign rd_rec = vmrwt_pkg::rec_type'(rd_data);

   vmrwt_ram #(
      .WIDTH (vmrwt_pkg::REC_W),
      .DEPTH (vmrwt_pkg::TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (iss_ff[vmrwt_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   vmrwt_entry_eval u_eval (
      .req (req_ff),
      .rec (rd_rec),
      .ev  (ev)
   );

   always_comb begin
      logic                   issue_ok;
      logic                   scan_done;
      logic                   respond;
      logic                   verdict;
      vmrwt_pkg::status_type  status;
      logic                   cyc;

      state_in     = state_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      iss_in       = iss_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      hold_cnt_in  = hold_cnt_ff;
      wfree_in     = wfree_ff;
      whold_in     = whold_ff;
      fit_in       = fit_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = pidx_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      respond      = 1'b0;
      verdict      = 1'b0;
      status       = vmrwt_pkg::STAT_OK;
      cyc          = 1'b0;

      issue_ok  = (iss_ff < cnt_ff);
      scan_done = !pend_ff && !issue_ok;

      for (int k = 0; k < NK; k++) begin
         cyc = cyc || (wfree_ff[k] && (hold_cnt_ff[k] != 2'd0))
                   || (whold_ff[k] && (hold_cnt_ff[k] == HOLD_SAT));
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               iss_in   = '0;
               wfree_in = '0;
               whold_in = '0;
               fit_in   = 1'b0;
               for (int k = 0; k < NK; k++) begin
                  hold_cnt_in[k] = 2'd0;
               end
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (issue_ok) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = iss_ff[vmrwt_pkg::ADDR_W-1:0];
               iss_in  = iss_ff + vmrwt_pkg::cnt_type'(1);
            end
            if (pend_ff) begin
               // A waiter that holds nothing of a kind clashes with any holder;
               // a waiter that also holds it needs a second holder.
               for (int k = 0; k < NK; k++) begin
                  if (ev.held_nz[k] && (hold_cnt_ff[k] != HOLD_SAT)) begin
                     hold_cnt_in[k] = hold_cnt_ff[k] + 2'd1;
                  end
               end
               wfree_in = wfree_ff | (ev.wait_nz & ~ev.held_nz);
               whold_in = whold_ff | (ev.wait_nz & ev.held_nz);
               fit_in   = fit_ff || (ev.fits && !ev.id_match);
            end
            priority if (pend_ff && ev.id_match && req_ff.cmd == vmrwt_pkg::CMD_ADD) begin
               wr_en    = 1'b1;
               wr_addr  = pidx_ff;
               wr_data  = vmrwt_pkg::make_rec(req_ff);
               pend_in  = 1'b0;
               respond  = 1'b1;
            end else if (pend_ff && ev.id_match
                         && req_ff.cmd == vmrwt_pkg::CMD_REMOVE) begin
               iss_in   = vmrwt_pkg::cnt_type'(pidx_ff) + vmrwt_pkg::cnt_type'(1);
               pend_in  = 1'b0;
               state_in = ST_SHIFT;
            end else if (scan_done) begin
               respond = 1'b1;
               unique case (req_ff.cmd)
                  vmrwt_pkg::CMD_ADD: begin
                     if (cnt_ff != vmrwt_pkg::cnt_type'(vmrwt_pkg::TABLE_DEPTH)) begin
                        wr_en   = 1'b1;
                        wr_addr = cnt_ff[vmrwt_pkg::ADDR_W-1:0];
                        wr_data = vmrwt_pkg::make_rec(req_ff);
                        cnt_in  = cnt_ff + vmrwt_pkg::cnt_type'(1);
                     end else begin
                        status = vmrwt_pkg::STAT_FULL;
                     end
                  end
                  vmrwt_pkg::CMD_REMOVE: status  = vmrwt_pkg::STAT_NOT_FOUND;
                  vmrwt_pkg::CMD_CYCLE:  verdict = cyc;
                  vmrwt_pkg::CMD_SAFETY: begin
                     verdict = (cnt_ff <= vmrwt_pkg::cnt_type'(1)) || fit_ff;
                  end
                  default: verdict = 1'b0;
               endcase
            end
         end

         ST_SHIFT: begin
            if (issue_ok) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = iss_ff[vmrwt_pkg::ADDR_W-1:0];
               iss_in  = iss_ff + vmrwt_pkg::cnt_type'(1);
            end
            // Each record read back moves one place down.
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pidx_ff - vmrwt_pkg::addr_type'(1);
               wr_data = rd_data;
            end
            if (scan_done) begin
               cnt_in  = cnt_ff - vmrwt_pkg::cnt_type'(1);
               respond = 1'b1;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      if (respond) begin
         state_in           = ST_IDLE;
         rsp_valid_in       = 1'b1;
         rsp_in.verdict     = verdict;
         rsp_in.status      = status;
         rsp_in.entry_count = cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      iss_ff      <= iss_in;
      pidx_ff     <= pidx_in;
      hold_cnt_ff <= hold_cnt_in;
      wfree_ff    <= wfree_in;
      whold_ff    <= whold_in;
      fit_ff      <= fit_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- src/vmrwt_checker.sv -----
// Port-level checks for the requester wait table, bound to its top level.
// Depends on vmrwt_pkg and vm_resource_wait_table_assert.svh.
`include "vm_resource_wait_table_assert.svh"

module vmrwt_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input vmrwt_pkg::rsp_type rsp_data
);

   logic beat_in;
   logic full_rsp;
   logic at_depth;

   assign beat_in  = start && !busy;
   assign full_rsp = rsp_valid && (rsp_data.status == vmrwt_pkg::STAT_FULL);
   assign at_depth = (rsp_data.entry_count == vmrwt_pkg::cnt_type'(vmrwt_pkg::TABLE_DEPTH));

   // An accepted beat keeps the block busy until its result is shown.
   `VMRWT_ASSERT_NEXT(a_accept_busy, clock, reset, beat_in, busy, "accepted beat left busy low")

   `VMRWT_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy, "result shown while still busy")

   // Every item passes through the scan state, so results never come back to back.
   `VMRWT_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "strobe held two cycles")

   `VMRWT_ASSERT_SAME(a_full_count, clock, reset, full_rsp, at_depth, "full status with room left")

endmodule

bind vm_resource_wait_table vmrwt_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
